FILE: src/lft_pkg.sv
// ----------------------------------------------------------------------------
// lft_pkg
// Shared types, constants and helpers for the local frame transform unit.
// ----------------------------------------------------------------------------
package lft_pkg;

  localparam int DefCordicSteps = 16;
  localparam int DefValueWidth  = 32;
  localparam int MaxSteps       = 30;

  localparam logic [31:0] CordicGain = 32'd652032874;

  typedef enum logic [2:0] {
    OP_TRANSLATE  = 3'd0,
    OP_SET_EXTENT = 3'd1,
    OP_ROT_X      = 3'd2,
    OP_ROT_Y      = 3'd3,
    OP_ROT_Z      = 3'd4,
    OP_READ_XFORM = 3'd5,
    OP_READ_ORG   = 3'd6,
    OP_READ_EXT   = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [15:0]        turn_angle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         column_index;
    logic               last_of_run;
    logic signed [31:0] elem_a;
    logic signed [31:0] elem_b;
    logic signed [31:0] elem_c;
  } out_item_t;

  // Datapath commands from the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,      // capture the input item
    CMD_EDIT,      // translate or set extent
    CMD_CORDIC,    // one CORDIC iteration
    CMD_ROT_MUL,   // one rotation product
    CMD_ROT_WR,    // write one rotated component pair
    CMD_COL_MUL,   // one column product
    CMD_COL_ACC,   // accumulate a column element
    CMD_EMIT       // load output register
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [4:0] step;   // CORDIC step
    logic [1:0] col;    // column or component
    logic [1:0] elem;   // element 0..2, or rotation product 0..3
    logic       sub;    // column 3: row 0 when low, rows 1 and 2 when high
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    op_t operation;
  } dp_stat_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'h20000000;  5'd1:  t = 32'h12E4051D;
      5'd2:  t = 32'h09FB385B;  5'd3:  t = 32'h051111D4;
      5'd4:  t = 32'h028B0D43;  5'd5:  t = 32'h0145D7E1;
      5'd6:  t = 32'h00A2F61E;  5'd7:  t = 32'h00517C55;
      5'd8:  t = 32'h0028BE53;  5'd9:  t = 32'h00145F2E;
      5'd10: t = 32'h000A2F98;  5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6;  5'd13: t = 32'h000145F3;
      5'd14: t = 32'h0000A2F9;  5'd15: t = 32'h0000517C;
      5'd16: t = 32'h000028BE;  5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F;  5'd19: t = 32'h00000517;
      5'd20: t = 32'h0000028B;  5'd21: t = 32'h00000145;
      5'd22: t = 32'h000000A2;  5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028;  5'd25: t = 32'h00000014;
      5'd26: t = 32'h0000000A;  5'd27: t = 32'h00000005;
      5'd28: t = 32'h00000002;  5'd29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

FILE: src/lft_ctrl.sv
// ----------------------------------------------------------------------------
// lft_ctrl
// Sequencer: accepts one item, steps the datapath, hands results out.
// ----------------------------------------------------------------------------
module lft_ctrl #(
  parameter int CORDIC_STEPS = lft_pkg::DefCordicSteps
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  lft_pkg::dp_stat_t stat,
  output lft_pkg::dp_cmd_t  cmd,
  output logic              out_valid,
  input  logic              out_stall
);
  import lft_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_CORDIC, S_RMUL, S_RWR, S_CMUL, S_CACC, S_EMIT, S_WAIT
  } state_t;

  localparam int StepW = 5;
  localparam logic [StepW-1:0] LastStep = StepW'(CORDIC_STEPS - 1);

  state_t          state;
  logic [StepW-1:0] step;
  logic [1:0]       col;
  logic [1:0]       elem;
  logic             sub;
  logic             last;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.op   = CMD_NONE;
    cmd.step = step;
    cmd.col  = col;
    cmd.elem = elem;
    cmd.sub  = sub;
    cmd.last = last;
    unique case (state)
      S_IDLE:   if (in_valid) cmd.op = CMD_LOAD;
      S_DECODE: if (stat.operation == OP_TRANSLATE || stat.operation == OP_SET_EXTENT)
                  cmd.op = CMD_EDIT;
      S_CORDIC: cmd.op = CMD_CORDIC;
      S_RMUL:   cmd.op = CMD_ROT_MUL;
      S_RWR:    cmd.op = CMD_ROT_WR;
      S_CMUL:   cmd.op = CMD_COL_MUL;
      S_CACC:   cmd.op = CMD_COL_ACC;
      S_EMIT:   if (!out_valid || !out_stall) cmd.op = CMD_EMIT;
      S_WAIT:   cmd.op = CMD_NONE;
      default:  cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      col       <= '0;
      elem      <= '0;
      sub       <= 1'b0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          step <= '0; col <= '0; elem <= '0; sub <= 1'b0; last <= 1'b0;
          unique case (stat.operation)
            OP_TRANSLATE, OP_SET_EXTENT: state <= S_IDLE;
            OP_ROT_X, OP_ROT_Y, OP_ROT_Z: state <= S_CORDIC;
            OP_READ_XFORM: state <= S_CMUL;
            OP_READ_ORG, OP_READ_EXT: begin
              last  <= 1'b1;
              state <= S_EMIT;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_CORDIC: begin
          step <= step + 1'b1;
          if (step == LastStep) state <= S_RMUL;
        end
        // four products per component: a*c, b*s, b*c, a*s
        S_RMUL: begin
          elem <= elem + 1'b1;
          if (elem == 2'd3) state <= S_RWR;
        end
        S_RWR: begin
          elem <= '0;
          col  <= col + 1'b1;
          state <= (col == 2'd2) ? S_WAIT : S_RMUL;
        end
        // columns 0..2 need one product per element, column 3 three
        S_CMUL: state <= S_CACC;
        S_CACC: begin
          if (col == 2'd3 && sub == 1'b0 && elem != 2'd2) begin
            elem  <= elem + 1'b1;
            state <= S_CMUL;
          end else if (col == 2'd3 && sub == 1'b0) begin
            elem  <= '0;
            sub   <= 1'b1;
            state <= S_CMUL;
          end else if (col == 2'd3) begin
            // sub selects rows 1 and 2; step counts them from 0
            if (elem == 2'd2 && step == 5'd1) begin
              last  <= 1'b1;
              state <= S_EMIT;
            end else if (elem == 2'd2) begin
              elem  <= '0;
              step  <= step + 1'b1;
              state <= S_CMUL;
            end else begin
              elem  <= elem + 1'b1;
              state <= S_CMUL;
            end
          end else if (elem == 2'd2) begin
            state <= S_EMIT;
          end else begin
            elem  <= elem + 1'b1;
            state <= S_CMUL;
          end
        end
        S_EMIT: if (!out_valid || !out_stall) begin
          if (last) state <= S_WAIT;
          else begin
            col   <= col + 1'b1;
            elem  <= '0;
            sub   <= 1'b0;
            step  <= '0;
            state <= S_CMUL;
          end
        end
        S_WAIT: if (!out_valid || !out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_cordic_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORDIC) |-> (step <= LastStep)) else $error("cordic overrun");
`endif

endmodule

FILE: src/lft_dp.sv
// ----------------------------------------------------------------------------
// lft_dp
// Frame state, CORDIC, shared Q2.30 multiplier and output register.
// ----------------------------------------------------------------------------
module lft_dp #(
  parameter int CORDIC_STEPS = lft_pkg::DefCordicSteps,
  parameter int VALUE_WIDTH  = lft_pkg::DefValueWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  lft_pkg::in_item_t  in_item,
  input  lft_pkg::dp_cmd_t   cmd,
  output lft_pkg::dp_stat_t  stat,
  output lft_pkg::out_item_t out_item
);
  import lft_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int MW = (VW > 32) ? VW : 32; // operand width, covers values and axes
  localparam int PW = MW + 34;             // product width
  localparam int AW = MW + 3;              // accumulator width

  localparam logic signed [VW-1:0] VMax = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMin = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [31:0]  Q30One = 32'sh40000000;

  in_item_t item;
  logic signed [VW-1:0] origin [3];
  logic signed [VW-1:0] extent [3];
  logic signed [31:0]   axes   [9];

  // CORDIC registers
  logic signed [33:0] cx, cy;
  logic signed [33:0] cz;
  logic [1:0]         quad;
  logic signed [33:0] cos_v, sin_v;

  // multiplier and accumulators
  logic signed [MW+1:0] prod;
  logic signed [MW+1:0] rp [4];
  logic signed [AW-1:0] acc [3];

  function automatic logic signed [VW-1:0] sat_v(input logic signed [MW+1:0] v);
    if (v > (MW+2)'(VMax)) return VMax;
    if (v < (MW+2)'(VMin)) return VMin;
    return v[VW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    if (v > $signed(AW'(32'sh7fffffff))) return 32'sh7fffffff;
    if (v < $signed({{(AW-32){1'b1}}, 32'h80000000})) return 32'sh80000000;
    return v[31:0];
  endfunction

  // axis index of pair (a, b) for the rotation
  logic [1:0] ka, kb;
  always_comb begin
    unique case (op_t'(item.operation))
      OP_ROT_X: begin ka = 2'd1; kb = 2'd2; end
      OP_ROT_Y: begin ka = 2'd2; kb = 2'd0; end
      default:  begin ka = 2'd0; kb = 2'd1; end
    endcase
  end

  // multiplier operand selection
  logic signed [MW-1:0] mv;
  logic signed [33:0]   mf;
  logic signed [31:0]   av, bv;
  logic [3:0]           ai, bi;
  always_comb begin
    ai = 4'(3 * ka + cmd.col);
    bi = 4'(3 * kb + cmd.col);
    av = axes[ai];
    bv = axes[bi];
    mv = '0;
    mf = '0;
    if (cmd.op == CMD_ROT_MUL) begin
      unique case (cmd.elem)
        2'd0: begin mv = MW'(av); mf = cos_v; end
        2'd1: begin mv = MW'(bv); mf = sin_v; end
        2'd2: begin mv = MW'(bv); mf = cos_v; end
        default: begin mv = MW'(av); mf = sin_v; end
      endcase
    end else if (cmd.col != 2'd3) begin
      mv = MW'(extent[cmd.col]);
      mf = 34'(axes[4'(3 * cmd.elem + cmd.col)]);
    end else begin
      // row 0 while sub is low, then rows 1 and 2 from step; element index elem
      mv = MW'(origin[cmd.elem]);
      mf = 34'(axes[4'(3 * (cmd.sub ? cmd.step[1:0] + 2'd1 : 2'd0) + cmd.elem)]);
    end
  end

  // round-half-up of mv*mf/2^30
  logic signed [PW-1:0] full;
  always_comb full = (PW'(mv) * PW'(mf)) + (PW'(1) <<< 29);

  assign stat.operation = op_t'(item.operation);

  logic signed [15:0] resid;
  logic [1:0]         q_in;
  always_comb begin
    q_in  = 2'(({1'b0, item.turn_angle} + 17'd8192) >> 14);
    resid = $signed(item.turn_angle - {q_in, 14'd0});
  end

  logic [1:0] row;
  always_comb row = cmd.sub ? 2'(cmd.step[1:0] + 2'd1) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        extent[i] <= VW'(65536);
      end
      for (int i = 0; i < 9; i++) axes[i] <= (i % 4 == 0) ? Q30One : 32'sd0;
    end else begin
      unique case (cmd.op)
        CMD_LOAD: item <= in_item;
        CMD_EDIT: begin
          if (op_t'(item.operation) == OP_TRANSLATE) begin
            origin[0] <= sat_v((MW+2)'(origin[0]) + (MW+2)'(item.vec_x));
            origin[1] <= sat_v((MW+2)'(origin[1]) + (MW+2)'(item.vec_y));
            origin[2] <= sat_v((MW+2)'(origin[2]) + (MW+2)'(item.vec_z));
          end else begin
            extent[0] <= sat_v((MW+2)'(item.vec_x));
            extent[1] <= sat_v((MW+2)'(item.vec_y));
            extent[2] <= sat_v((MW+2)'(item.vec_z));
          end
        end
        CMD_CORDIC: begin
          if (cmd.step == '0) begin
            quad <= q_in;
          end
          begin
            logic signed [33:0] x0, y0, z0, d0x, d0y;
            x0  = (cmd.step == '0) ? 34'(CordicGain) : cx;
            y0  = (cmd.step == '0) ? 34'sd0 : cy;
            z0  = (cmd.step == '0) ? 34'(resid) <<< 16 : cz;
            d0x = y0 >>> cmd.step;
            d0y = x0 >>> cmd.step;
            if (!z0[33]) begin
              cx <= x0 - d0x; cy <= y0 + d0y; cz <= z0 - 34'(atan_turn(cmd.step));
            end else begin
              cx <= x0 + d0x; cy <= y0 - d0y; cz <= z0 + 34'(atan_turn(cmd.step));
            end
            if (cmd.step == 5'(CORDIC_STEPS - 1)) begin
              logic signed [33:0] xf, yf;
              xf = (!z0[33]) ? x0 - d0x : x0 + d0x;
              yf = (!z0[33]) ? y0 + d0y : y0 - d0y;
              unique case ((cmd.step == '0) ? q_in : quad)
                2'd0: begin cos_v <= xf;  sin_v <= yf;  end
                2'd1: begin cos_v <= -yf; sin_v <= xf;  end
                2'd2: begin cos_v <= -xf; sin_v <= -yf; end
                default: begin cos_v <= yf; sin_v <= -xf; end
              endcase
            end
          end
        end
        CMD_ROT_MUL: rp[cmd.elem] <= (MW+2)'(full >>> 30);
        CMD_ROT_WR: begin
          axes[ai] <= sat32(AW'(rp[0]) + AW'(rp[1]));
          axes[bi] <= sat32(AW'(rp[2]) - AW'(rp[3]));
        end
        CMD_COL_MUL: prod <= (MW+2)'(full >>> 30);
        CMD_COL_ACC: begin
          if (cmd.col != 2'd3) acc[cmd.elem] <= AW'(prod);
          else if (cmd.elem == 2'd0) acc[row] <= AW'(prod);
          else acc[row] <= acc[row] + AW'(prod);
        end
        CMD_EMIT: begin
          out_item.column_index <= cmd.col;
          out_item.last_of_run  <= cmd.last;
          if (op_t'(item.operation) == OP_READ_ORG) begin
            out_item.column_index <= '0;
            out_item.elem_a <= sat32(AW'(origin[0]));
            out_item.elem_b <= sat32(AW'(origin[1]));
            out_item.elem_c <= sat32(AW'(origin[2]));
          end else if (op_t'(item.operation) == OP_READ_EXT) begin
            out_item.column_index <= '0;
            out_item.elem_a <= sat32(AW'(extent[0]));
            out_item.elem_b <= sat32(AW'(extent[1]));
            out_item.elem_c <= sat32(AW'(extent[2]));
          end else begin
            out_item.elem_a <= sat32(acc[0]);
            out_item.elem_b <= sat32(acc[1]);
            out_item.elem_c <= sat32(acc[2]);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: src/local_frame_transform_unit.sv
// Per item: an edit is decoded and applied; a rotation runs decode, the
// CORDIC iterations, 12 products and 3 writes through one multiplier, one wait.
// Read transform: 4 results, one per column. Origin/extent reads: one result.
// One item in work at a time; output stalls hold the sequencer.
// Synchronous reset restores zero origin, unit extent and identity axes.
// ----------------------------------------------------------------------------
// local_frame_transform_unit
// Top level: sequencer plus frame datapath.
// ----------------------------------------------------------------------------
module local_frame_transform_unit #(
  parameter int CORDIC_STEPS = lft_pkg::DefCordicSteps,
  parameter int VALUE_WIDTH  = lft_pkg::DefValueWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lft_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lft_pkg::out_item_t out_data
);
  import lft_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lft_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .stat, .cmd, .out_valid, .out_stall
  );

  lft_dp #(.CORDIC_STEPS(CORDIC_STEPS), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .stat, .out_item(out_data)
  );

endmodule
